// ===== rtl/scf_pkg.sv =====
// Shared item types and command/event codes for the serial command framer.
`timescale 1ns / 1ps
`default_nettype none

package scf_pkg;

  // Command letters recognised in idle phase
  localparam logic [7:0] CmdReset  = 8'h52;  // 'R'
  localparam logic [7:0] CmdState  = 8'h53;  // 'S'
  localparam logic [7:0] CmdStart  = 8'h54;  // 'T'
  localparam logic [7:0] CmdResend = 8'h55;  // 'U'

  // Event codes carried in event_res
  localparam logic [2:0] EvNone   = 3'd0;
  localparam logic [2:0] EvReset  = 3'd1;
  localparam logic [2:0] EvResend = 3'd2;
  localparam logic [2:0] EvState  = 3'd3;
  localparam logic [2:0] EvByte   = 3'd4;
  localparam logic [2:0] EvDone   = 3'd5;
  localparam logic [2:0] EvLong   = 3'd6;
  localparam logic [2:0] EvZero   = 3'd7;

  // Link state reported for codes with no meaning
  localparam logic [2:0] LinkUnknown = 3'd6;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic [2:0] link_state;
  } in_item_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic [2:0] reported_state;
    logic [4:0] byte_index;
    logic [7:0] byte_value;
    logic [5:0] frame_length;
  } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/serial_command_framer.sv =====
// Top level of the serial command framer: decoder and result buffer.
`timescale 1ns / 1ps
`default_nettype none

// Serial command framer. Each input item is one received byte with the current
// link state; each accepted item yields exactly one result item, in order. In
// idle phase 'R', 'U' and 'S' give reset, resend and state report events (link
// states 6 and 7 report as unknown), and 'T' opens a frame whose next byte is
// its length (1 to MAX_PAYLOAD, else a too-long or zero-length error event).
// The payload bytes then come out with their index, the last flagged as frame
// done with the length. Throughput is one item per clock while in_stall_o is
// low: the decode is a few byte compares and a counter step from the phase/
// length/count registers into the output register (the skid register if held).
// A skid register behind the output holds one more result, so input is only
// stalled once two results are waiting; in_stall_o is a register output.

module serial_command_framer #(
  parameter int MAX_PAYLOAD = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire scf_pkg::in_item_t  in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output scf_pkg::out_item_t      out_item_o
);

  logic               in_accept;
  logic               buf_full;
  scf_pkg::out_item_t result;

  // stall only when both result slots are taken
  assign in_stall_o = buf_full;
  assign in_accept  = in_valid_i && !buf_full;

  scf_decoder #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_decoder (
    .clk_i,
    .rst_ni,
    .accept_i (in_accept),
    .item_i   (in_item_i),
    .result_o (result)
  );

  scf_out_buffer u_out_buffer (
    .clk_i,
    .rst_ni,
    .push_i      (in_accept),
    .push_item_i (result),
    .full_o      (buf_full),
    .out_valid_o,
    .out_stall_i,
    .out_item_o
  );

endmodule

`default_nettype wire

// ===== rtl/scf_decoder.sv =====
// Command decoder and frame tracker: phase, length and count registers.
`timescale 1ns / 1ps
`default_nettype none

module scf_decoder #(
  parameter int MAX_PAYLOAD = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire scf_pkg::in_item_t item_i,
  output scf_pkg::out_item_t     result_o
);

  localparam int CntW = $clog2(MAX_PAYLOAD + 1);

  typedef enum logic [1:0] {
    PhIdle = 2'd0,
    PhLen  = 2'd1,
    PhData = 2'd2
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [CntW-1:0] exp_q, exp_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  logic [7:0] cnt_w, exp_w;
  logic       last_byte;

  assign cnt_w     = 8'(cnt_q);
  assign exp_w     = 8'(exp_q);
  assign last_byte = ((CntW + 1)'(cnt_q) + (CntW + 1)'(1)) >= {1'b0, exp_q};

  always_comb begin
    phase_d  = phase_q;
    exp_d    = exp_q;
    cnt_d    = cnt_q;
    result_o = '0;
    case (phase_q)
      PhLen: begin
        if ({1'b0, item_i.rx_byte} > 9'(MAX_PAYLOAD)) begin
          result_o.event_res = scf_pkg::EvLong;
          phase_d            = PhIdle;
        end else if (item_i.rx_byte == 8'd0) begin
          result_o.event_res = scf_pkg::EvZero;
          phase_d            = PhIdle;
        end else begin
          exp_d   = CntW'(item_i.rx_byte);
          cnt_d   = '0;
          phase_d = PhData;
        end
      end
      PhData: begin
        result_o.byte_index = cnt_w[4:0];
        result_o.byte_value = item_i.rx_byte;
        if (last_byte) begin
          result_o.event_res    = scf_pkg::EvDone;
          result_o.frame_length = exp_w[5:0];
          cnt_d                 = '0;
          phase_d               = PhIdle;
        end else begin
          result_o.event_res = scf_pkg::EvByte;
          cnt_d              = cnt_q + CntW'(1);
        end
      end
      default: begin
        // idle, and the unused phase code behaves as idle
        phase_d = PhIdle;
        case (item_i.rx_byte)
          scf_pkg::CmdReset:  result_o.event_res = scf_pkg::EvReset;
          scf_pkg::CmdResend: result_o.event_res = scf_pkg::EvResend;
          scf_pkg::CmdState: begin
            result_o.event_res      = scf_pkg::EvState;
            result_o.reported_state = (item_i.link_state inside {[3'd0:3'd5]}) ?
                                      item_i.link_state : scf_pkg::LinkUnknown;
          end
          scf_pkg::CmdStart: begin
            phase_d = PhLen;
            exp_d   = '0;
          end
          default: ;
        endcase
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      exp_q   <= '0;
      cnt_q   <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      exp_q   <= exp_d;
      cnt_q   <= cnt_d;
    end
  end

  a_count_below_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhData) |-> (cnt_q < exp_q))
    else $error("payload count reached frame length");

  a_data_events: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && phase_q == PhData) |->
      (result_o.event_res == scf_pkg::EvByte || result_o.event_res == scf_pkg::EvDone))
    else $error("payload byte without byte or done event");

  a_zero_length_aborts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && phase_q == PhLen && item_i.rx_byte == 8'd0) |=> (phase_q == PhIdle))
    else $error("zero length did not return to idle");

endmodule

`default_nettype wire

// ===== rtl/scf_out_buffer.sv =====
// Two-entry result buffer: output register plus skid register.
`timescale 1ns / 1ps
`default_nettype none

module scf_out_buffer (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire scf_pkg::out_item_t push_item_i,
  output logic                    full_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output scf_pkg::out_item_t      out_item_o
);

  logic               out_valid_q, out_valid_d;
  logic               sk_valid_q, sk_valid_d;
  scf_pkg::out_item_t out_q, out_d;
  scf_pkg::out_item_t sk_q, sk_d;
  logic               pop;

  assign pop = out_valid_q && !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    sk_valid_d  = sk_valid_q;
    out_d       = out_q;
    sk_d        = sk_q;
    if (pop || !out_valid_q) begin
      // output register is free this cycle: skid entry goes first
      if (sk_valid_q) begin
        out_d       = sk_q;
        out_valid_d = 1'b1;
        sk_valid_d  = push_i;
        sk_d        = push_item_i;
      end else begin
        out_d       = push_item_i;
        out_valid_d = push_i;
      end
    end else if (push_i) begin
      sk_d       = push_item_i;
      sk_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sk_valid_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      sk_valid_q  <= sk_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    sk_q  <= sk_d;
  end

  assign full_o      = sk_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_skid_behind_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sk_valid_q |-> out_valid_q)
    else $error("skid entry held with output register empty");

  a_skid_moves_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && sk_valid_q) |=> (out_valid_q && out_q == $past(sk_q)))
    else $error("skid entry lost on output pop");

  a_skid_fills_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(sk_valid_q) |-> $past(out_valid_q && out_stall_i && push_i))
    else $error("skid filled while output was free");

endmodule

`default_nettype wire
